// ===== hdl/nrb_pkg.sv =====
// Shared types and codes for the NACK retransmission buffer.
`default_nettype none

package nrb_pkg;

  // input message codes
  localparam logic [1:0] OP_APP     = 2'd0;
  localparam logic [1:0] OP_CONNECT = 2'd1;
  localparam logic [1:0] OP_NACK    = 2'd2;
  localparam logic [1:0] OP_OTHER   = 2'd3;

  // result message kinds
  localparam logic [1:0] MSG_DATA   = 2'd0;
  localparam logic [1:0] MSG_ACCEPT = 2'd1;
  localparam logic [1:0] MSG_REJECT = 2'd2;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_STORE  = 2'd0;
  localparam logic [1:0] CMD_CTRL   = 2'd1;
  localparam logic [1:0] CMD_NACK   = 2'd2;

  localparam int CMDQ_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] payload;
    logic [31:0] now_time;
    logic [31:0] nack_seq;
    logic [47:0] peer_addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  msg_kind;
    logic [47:0] dest_addr;
    logic [31:0] out_seq;
    logic [63:0] out_payload;
    logic [31:0] out_time;
    logic        is_resend;
    logic [31:0] resend_count;
    logic [31:0] sent_count;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        emit;       // store: send as first-time data
    logic [1:0]  msg_kind;   // ctrl: accept or reject
    logic [47:0] dest;
    logic [31:0] seq;        // store: new number, nack: requested number
    logic [63:0] payload;
    logic [31:0] stamp;
    logic [31:0] sent_count;
    logic [31:0] last_seq;   // ring fill snapshot for nack lookups
    logic        filled;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/nrb_front.sv =====
// Front end: classifies messages, numbers packets, tracks the connection.
`default_nettype none

module nrb_front #(
  parameter int RING_DEPTH = 1024
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  nrb_pkg::in_word_t in_word,
  input  wire              q_full,
  output logic             cmd_push,
  output nrb_pkg::cmd_t    cmd
);
  import nrb_pkg::*;

  logic        accept;
  logic [31:0] seq_inc;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic [31:0] sent_r, sent_nxt;
  logic [47:0] client_peer_r, client_peer_nxt;
  logic        connected_r, connected_nxt;
  logic        filled_r, filled_nxt;

  always_comb begin
    accept          = push && !q_full;
    seq_inc         = last_seq_r + 32'd1;
    last_seq_nxt    = last_seq_r;
    sent_nxt        = sent_r;
    client_peer_nxt = client_peer_r;
    connected_nxt   = connected_r;
    filled_nxt      = filled_r;
    cmd_push        = 1'b0;
    cmd.kind        = CMD_STORE;
    cmd.emit        = 1'b0;
    cmd.msg_kind    = MSG_DATA;
    cmd.dest        = client_peer_r;
    cmd.seq         = in_word.nack_seq;
    cmd.payload     = in_word.payload;
    cmd.stamp       = in_word.now_time;
    cmd.last_seq    = last_seq_r;
    cmd.filled      = filled_r;
    if (accept) begin
      unique case (in_word.op)
        OP_APP: begin
          cmd_push     = 1'b1;
          cmd.kind     = CMD_STORE;
          cmd.emit     = connected_r;
          cmd.seq      = seq_inc;
          last_seq_nxt = seq_inc;
          // every slot holds a packet once the ring has gone round once
          filled_nxt   = filled_r || (seq_inc == 32'(RING_DEPTH));
          if (connected_r) sent_nxt = sent_r + 32'd1;
        end
        OP_CONNECT: begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_CTRL;
          cmd.emit  = 1'b1;
          cmd.dest  = in_word.peer_addr;
          if (!connected_r) begin
            cmd.msg_kind    = MSG_ACCEPT;
            connected_nxt   = 1'b1;
            client_peer_nxt = in_word.peer_addr;
          end else begin
            cmd.msg_kind = MSG_REJECT;
          end
        end
        OP_NACK: begin
          cmd_push = connected_r;
          cmd.kind = CMD_NACK;
        end
        OP_OTHER: ;
        default: ;
      endcase
    end
    cmd.sent_count = sent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r    <= '0;
      sent_r        <= '0;
      client_peer_r <= '0;
      connected_r   <= 1'b0;
      filled_r      <= 1'b0;
    end else begin
      last_seq_r    <= last_seq_nxt;
      sent_r        <= sent_nxt;
      client_peer_r <= client_peer_nxt;
      connected_r   <= connected_nxt;
      filled_r      <= filled_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nrb_cmdq.sv =====
// Short command queue between front and back.
`default_nettype none

module nrb_cmdq (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  nrb_pkg::cmd_t push_word,
  output logic          full,
  input  wire           pop,
  output nrb_pkg::cmd_t pop_word,
  output logic          empty
);
  import nrb_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);

  cmd_t             store_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == (PTR_W+1)'(CMDQ_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_word;
  end

endmodule

`default_nettype wire

// ===== hdl/nrb_back.sv =====
// Back end: slot index, ring memory access, result build and output register.
`default_nettype none

module nrb_back #(
  parameter int RING_DEPTH    = 1024,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  nrb_pkg::cmd_t      q_word,
  input  wire                q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  wire                out_pop,
  output nrb_pkg::out_word_t out_word
);
  import nrb_pkg::*;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int SHIFT  = 32 + IDX_W;
  localparam int SLOT_W = 32 + PAYLOAD_WIDTH + 32;
  // round-up reciprocal: exact quotient for every 32-bit numerator
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam logic [32:0] RECIP   = RECIP64[32:0];
  localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

  logic [SLOT_W-1:0] ring_mem [RING_DEPTH];

  logic              adv;
  logic              a_v_r, b_v_r, c_v_r, d_v_r, out_v_r;
  cmd_t              a_cmd_r, b_cmd_r, c_cmd_r, d_cmd_r;
  logic [64:0]       a_prod;
  logic [31:0]       b_q_r, b_q_nxt;
  logic [31:0]       c_qd_r, c_qd_nxt;
  logic [31:0]       c_rem;
  logic [IDX_W-1:0]  c_idx;
  logic              c_ok;
  logic              d_ok_r;
  logic [SLOT_W-1:0] rd_r;
  logic [31:0]       rd_tag, rd_stamp;
  logic [PAYLOAD_WIDTH-1:0] rd_body;
  logic              d_hit, d_emit, nack_take;
  logic [31:0]       resend_r, resend_nxt;
  out_word_t         d_word, out_r;

  // whole pipeline moves when the output register is free or being taken
  assign adv   = !out_v_r || out_pop;
  assign q_pop = adv && !q_empty;

  // stage A: quotient by reciprocal
  assign a_prod  = 65'(a_cmd_r.seq) * 65'(RECIP);
  assign b_q_nxt = 32'(a_prod >> SHIFT);
  // stage B: quotient times depth
  assign c_qd_nxt = 32'(b_q_r * DEPTH32);
  // stage C: remainder is the slot; fill check from the front's snapshot
  assign c_rem = c_cmd_r.seq - c_qd_r;
  assign c_idx = c_rem[IDX_W-1:0];
  assign c_ok  = c_cmd_r.filled ||
                 ((c_idx != '0) && (32'(c_idx) <= c_cmd_r.last_seq));

  // stage D: slot contents are in rd_r
  assign rd_tag    = rd_r[SLOT_W-1 -: 32];
  assign rd_body   = rd_r[32 +: PAYLOAD_WIDTH];
  assign rd_stamp  = rd_r[31:0];
  assign d_hit     = d_ok_r && (rd_tag == d_cmd_r.seq);
  assign nack_take = adv && d_v_r && (d_cmd_r.kind == CMD_NACK) && d_hit;

  always_comb begin
    d_emit                = 1'b0;
    resend_nxt            = resend_r;
    d_word.msg_kind       = MSG_DATA;
    d_word.dest_addr      = d_cmd_r.dest;
    d_word.out_seq        = '0;
    d_word.out_payload    = '0;
    d_word.out_time       = '0;
    d_word.is_resend      = 1'b0;
    d_word.sent_count     = d_cmd_r.sent_count;
    unique case (d_cmd_r.kind)
      CMD_STORE: begin
        d_emit             = d_cmd_r.emit;
        d_word.out_seq     = d_cmd_r.seq;
        d_word.out_payload = 64'(d_cmd_r.payload[PAYLOAD_WIDTH-1:0]);
        d_word.out_time    = d_cmd_r.stamp;
      end
      CMD_CTRL: begin
        d_emit          = 1'b1;
        d_word.msg_kind = d_cmd_r.msg_kind;
      end
      CMD_NACK: begin
        d_emit             = d_hit;
        d_word.out_seq     = d_cmd_r.seq;
        d_word.out_payload = 64'(rd_body);
        d_word.out_time    = rd_stamp;
        d_word.is_resend   = 1'b1;
        if (d_v_r && d_hit) resend_nxt = resend_r + 32'd1;
      end
      default: ;
    endcase
    d_word.resend_count = resend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      c_v_r    <= 1'b0;
      d_v_r    <= 1'b0;
      out_v_r  <= 1'b0;
      resend_r <= '0;
    end else if (adv) begin
      a_v_r    <= !q_empty;
      b_v_r    <= a_v_r;
      c_v_r    <= b_v_r;
      d_v_r    <= c_v_r;
      out_v_r  <= d_v_r && d_emit;
      if (d_v_r) resend_r <= resend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r <= q_word;
      b_cmd_r <= a_cmd_r;
      b_q_r   <= b_q_nxt;
      c_cmd_r <= b_cmd_r;
      c_qd_r  <= c_qd_nxt;
      d_cmd_r <= c_cmd_r;
      d_ok_r  <= c_ok;
      out_r   <= d_word;
    end
  end

  // ring memory: one access a cycle while the pipeline advances, registered read
  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_v_r && (c_cmd_r.kind == CMD_STORE))
        ring_mem[c_idx] <= {c_cmd_r.seq, c_cmd_r.payload[PAYLOAD_WIDTH-1:0],
                            c_cmd_r.stamp};
      rd_r <= ring_mem[c_idx];
    end
  end

  assign out_empty = !out_v_r;
  assign out_word  = out_r;

  a_resend_step: assert property (@(posedge clk) disable iff (!rst_n)
    nack_take |=> (resend_r == $past(resend_r) + 32'd1))
    else $error("resend counter did not step on a resend");

  a_resend_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (resend_r != $past(resend_r))) |-> $past(nack_take))
    else $error("resend counter moved without a resend");

  a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.msg_kind != MSG_DATA)) |->
      ((out_r.out_seq == 32'd0) && !out_r.is_resend))
    else $error("accept or reject word carries data fields");

endmodule

`default_nettype wire

// ===== hdl/nack_retransmit_buffer_top.sv =====
// Top level of the NACK retransmission buffer.
//
// Input side is a queue: drive in_word and push; a word is taken at a clock
// edge with push high and full low. op selects application packet, connect
// request, nack or other (dropped).
// Result side is a queue too: while empty is low the oldest result is on
// out_word; it is taken at an edge with pop high.
// A packet always gets the next sequence number and lands in ring slot
// seq mod RING_DEPTH; it is sent only once a peer has connected. A nack hit
// resends the stored word with its original time stamp.
// Path of a word: command queue, two multiply stages for the slot index,
// ring memory read, result build. Throughput is one word per cycle while
// pop keeps the output register free; the single-port ring memory is
// touched once per word.
// Reset (rst_n low, synchronous) clears sequence, connection, counters and
// queues; the ring needs no clearing pass, a fill count marks live slots.
// When pop is held low with a result waiting, the back pipeline freezes, the
// four-entry command queue fills and full rises; nothing is lost.
`default_nettype none

module nack_retransmit_buffer_top #(
  parameter int RING_DEPTH    = 1024,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  output logic               full,
  input  nrb_pkg::in_word_t  in_word,
  output logic               empty,
  input  wire                pop,
  output nrb_pkg::out_word_t out_word
);
  import nrb_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic q_full, q_empty, q_pop;

  nrb_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // decouples classification from the ring pipeline
  nrb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_word (cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (cmd_out),
    .empty     (q_empty)
  );

  nrb_back #(
    .RING_DEPTH    (RING_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_word    (cmd_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_word  (out_word)
  );

  assign full = q_full;

endmodule

`default_nettype wire

// ===== tb/sv/tb_nack_retransmit_buffer_top.sv =====
// Self-checking testbench for the NACK retransmission buffer: predicted words vs. results.
module tb_nack_retransmit_buffer_top;
  import nrb_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int RAND_WORDS  = 1900;
  localparam int CYCLE_LIMIT = 100000;
  // settle time at the end covers the result latency amply
  localparam int SETTLE      = 40;

  // Sender-side model: sequence numbering, ring of stored packets, peer
  // binding and the two counters. Each accepted input word may add one
  // expected result word to the queue.
  class sender_ring_model;
    logic [31:0] seq_last;
    bit          linked;
    logic [47:0] client;
    logic [31:0] resends;
    logic [31:0] firsts;
    bit          slot_live [RING_DEPTH];
    logic [31:0] slot_seq  [RING_DEPTH];
    logic [63:0] slot_body [RING_DEPTH];
    logic [31:0] slot_stamp[RING_DEPTH];
    out_word_t   due_msgs[$];
    int          errors;

    function new();
      seq_last = '0;
      linked   = 1'b0;
      client   = '0;
      resends  = '0;
      firsts   = '0;
      errors   = 0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    function void absorb_word(in_word_t w);
      int unsigned idx;
      out_word_t   m;
      bit          emits;
      m     = '0;
      emits = 1'b0;
      case (w.op)
        OP_APP: begin
          seq_last = seq_last + 32'd1;
          idx = seq_last % RING_DEPTH;
          slot_live[idx]  = 1'b1;
          slot_seq[idx]   = seq_last;
          slot_body[idx]  = w.payload;
          slot_stamp[idx] = w.now_time;
          if (linked) begin
            firsts        = firsts + 32'd1;
            m.msg_kind    = MSG_DATA;
            m.dest_addr   = client;
            m.out_seq     = seq_last;
            m.out_payload = w.payload;
            m.out_time    = w.now_time;
            emits         = 1'b1;
          end
        end
        OP_CONNECT: begin
          if (!linked) begin
            linked      = 1'b1;
            client      = w.peer_addr;
            m.msg_kind  = MSG_ACCEPT;
            m.dest_addr = client;
          end else begin
            m.msg_kind  = MSG_REJECT;
            m.dest_addr = w.peer_addr;
          end
          emits = 1'b1;
        end
        OP_NACK: begin
          idx = w.nack_seq % RING_DEPTH;
          if (linked && slot_live[idx] && slot_seq[idx] == w.nack_seq) begin
            resends       = resends + 32'd1;
            m.msg_kind    = MSG_DATA;
            m.dest_addr   = client;
            m.out_seq     = w.nack_seq;
            m.out_payload = slot_body[idx];
            m.out_time    = slot_stamp[idx];
            m.is_resend   = 1'b1;
            emits         = 1'b1;
          end
        end
        default: ;
      endcase
      if (emits) begin
        m.resend_count = resends;
        m.sent_count   = firsts;
        due_msgs.push_back(m);
      end
    endfunction

    function void field_chk(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_msg(out_word_t got);
      out_word_t want;
      if (due_msgs.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      want = due_msgs.pop_front();
      field_chk("msg_kind",     64'(want.msg_kind),     64'(got.msg_kind));
      field_chk("dest_addr",    64'(want.dest_addr),    64'(got.dest_addr));
      field_chk("out_seq",      64'(want.out_seq),      64'(got.out_seq));
      field_chk("out_payload",  want.out_payload,       got.out_payload);
      field_chk("out_time",     64'(want.out_time),     64'(got.out_time));
      field_chk("is_resend",    64'(want.is_resend),    64'(got.is_resend));
      field_chk("resend_count", 64'(want.resend_count), 64'(got.resend_count));
      field_chk("sent_count",   64'(want.sent_count),   64'(got.sent_count));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_word_t  in_word;
  logic      empty;
  logic      pop;
  out_word_t out_word;

  sender_ring_model sheet;
  int  cycle   = 0;
  int  rx_hold = 0;
  bit  tx_calm = 1'b0;

  nack_retransmit_buffer_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: ~25% idle per cycle, rare long stalls so the command queue
  // backs up and full rises, and one window with pop held high throughout.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      pop     <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (cycle >= 1200 && cycle < 1900) begin
      pop <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      pop     <= 1'b0;
      rx_hold <= $urandom_range(8, 30);
    end else begin
      pop <= ($urandom_range(0, 99) >= 25);
    end
  end

  // result monitor: values seen here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sheet.match_msg(out_word);
  end

  function automatic in_word_t mk_word(logic [1:0] op, logic [63:0] body, logic [31:0] stamp,
                                       logic [31:0] nseq, logic [47:0] peer);
    in_word_t w;
    w.op        = op;
    w.payload   = body;
    w.now_time  = stamp;
    w.nack_seq  = nseq;
    w.peer_addr = peer;
    return w;
  endfunction

  // offer one word and hold it until taken; the model sees it on acceptance
  task automatic push_word(input in_word_t w);
    in_word <= w;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sheet.absorb_word(w);
  endtask

  // sender gap, about a quarter of cycles idle unless in the calm stretch
  task automatic idle_gap();
    while (!tx_calm && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold the sender off until every expected word has come back
  task automatic drain_expected();
    push <= 1'b0;
    @(posedge clk);
    while (sheet.due_msgs.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t    plan[$];
    in_word_t    w;
    int unsigned r;
    int unsigned span;
    logic [31:0] nseq;

    sheet   = new();
    rst_n   = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    in_word = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    // ignored message and a nack before any peer is bound
    plan.push_back(mk_word(OP_OTHER, '1, '1, '1, '1));
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd0, '0));
    // packets stored while unconnected: numbered, not sent
    plan.push_back(mk_word(OP_APP, '1, '1, '0, '0));
    plan.push_back(mk_word(OP_APP, '0, '0, '1, '1));
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd1, '0));
    // first connect accepted, later ones rejected to the requester
    plan.push_back(mk_word(OP_CONNECT, '0, '0, '0, 48'hFFFF_FFFF_FFFF));
    plan.push_back(mk_word(OP_CONNECT, '1, '1, '1, 48'h0));
    // nack hits on packets stored before connect
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd1, '0));
    // sequence zero: slot 0 not yet written
    plan.push_back(mk_word(OP_NACK, '1, '1, 32'd0, '1));
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd2, '0));
    // empty slot
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd5, '0));
    plan.push_back(mk_word(OP_APP, 64'hA5A5_A5A5_A5A5_A5A5, 32'h1234_5678, '0, '0));
    plan.push_back(mk_word(OP_APP, 64'h5A5A_5A5A_5A5A_5A5A, 32'h8765_4321, '1, '1));
    // live slot, tag mismatch
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd3 + 32'd1024, '0));
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'hFFFF_FFFF, '0));
    plan.push_back(mk_word(OP_OTHER, '0, '0, 32'd3, '0));
    plan.push_back(mk_word(OP_NACK, '0, '0, 32'd4, '0));
    plan.push_back(mk_word(OP_NACK, '1, '1, 32'd3, '1));
    plan.push_back(mk_word(OP_CONNECT, '0, '0, '0, 48'h0123_4567_89AB));
    plan.push_back(mk_word(OP_APP, '1, 32'h0, '0, '0));
    foreach (plan[i]) begin
      push_word(plan[i]);
      idle_gap();
    end

    drain_expected();

    // random words: mostly packets and well-aimed nacks, some noise
    for (int n = 0; n < RAND_WORDS; n++) begin
      tx_calm = (n >= 500 && n < 800);
      if (n == 1000) drain_expected();
      w.payload   = {$urandom, $urandom};
      w.now_time  = $urandom;
      w.nack_seq  = $urandom;
      w.peer_addr = 48'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 45) begin
        w.op = OP_APP;
      end else if (r < 85) begin
        w.op = OP_NACK;
        r    = $urandom_range(0, 99);
        if (sheet.seq_last != 0 && r < 70) begin
          // recent packet still in the ring
          span = (sheet.seq_last < RING_DEPTH) ? sheet.seq_last - 1 : RING_DEPTH - 1;
          nseq = sheet.seq_last - 32'($urandom_range(0, span));
          w.nack_seq = nseq;
        end else if (r < 85) begin
          // overwritten slot or not yet sent
          w.nack_seq = sheet.seq_last - 32'd1024 - 32'($urandom_range(0, 500));
        end
      end else if (r < 92) begin
        w.op = OP_OTHER;
      end else begin
        w.op = OP_CONNECT;
      end
      push_word(w);
      idle_gap();
    end

    drain_expected();
    repeat (SETTLE) @(posedge clk);
    if (sheet.errors == 0 && sheet.due_msgs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== nack_retransmit_buffer_top.f =====
hdl/nrb_pkg.sv
hdl/nrb_front.sv
hdl/nrb_cmdq.sv
hdl/nrb_back.sv
hdl/nack_retransmit_buffer_top.sv
tb/sv/tb_nack_retransmit_buffer_top.sv
